// File: rtl/trur_pkg.sv
// shared widths, constants and types of the token rate utilization regulator
`default_nettype none
package trur_pkg;

  // field and state widths
  localparam int TICK_W    = 32;
  localparam int TOKEN_W   = 16;
  localparam int UTIL_W    = 7;
  localparam int LAUNCH_W  = 16;
  localparam int TARGET_W  = 7;
  localparam int PERIOD_W  = 10;

  // configuration port
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(1);

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(100);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(50);

  // token limits
  localparam logic [TOKEN_W-1:0] TOKEN_ONE = TOKEN_W'(1);
  localparam logic [TOKEN_W-1:0] WARM_MAX  = TOKEN_W'(3);
  localparam logic [TOKEN_W-1:0] TOKEN_MAX = '1;

  // datapath widths: |err| * cur, the step, the cap products
  localparam int PROD_W  = UTIL_W + LAUNCH_W;
  localparam int DELTA_W = (PROD_W > TOKEN_W) ? PROD_W : TOKEN_W;
  localparam int LHS_W   = DELTA_W + LAUNCH_W + 1;
  localparam int RHS_W   = LAUNCH_W + TOKEN_W;
  localparam int NUM_W   = 2 * LAUNCH_W + 1;
  localparam int NEXT_W  = DELTA_W + 2;

  // shared serial divider: dividend covers tick count and cap numerator,
  // divisor covers period, 4 * util and prev + 1
  localparam int DIV_DW    = (TICK_W > NUM_W) ? TICK_W : NUM_W;
  localparam int DIV_VW    = LAUNCH_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_DW + 1);

  // one sample request
  typedef struct packed {
    logic [UTIL_W-1:0]   util;
    logic [LAUNCH_W-1:0] cur;
    logic [LAUNCH_W-1:0] prev;
    logic                pending;
  } item_t;

  // one result
  typedef struct packed {
    logic [TOKEN_W-1:0] tokens;
    logic               updated;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/token_rate_utilization_regulator.sv
// top level: request and result channels, configuration registers, output register
//
// Usage:
//   Each request on the in channel (in_valid/in_ready) carries one utilization
//   sample: util_sample, cur_avg_launches, prev_avg_launches, update_pending.
//   Each request yields exactly one result on the out channel
//   (out_valid/out_ready): tokens_per_cycle after the step and updated.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data:
//   index 0 is target_limit, index 1 is sample_period.
//   One request is worked on at a time. A pending sample goes straight to the
//   result. Any other request counts a tick; past warm-up the shared serial
//   divider takes the tick modulo, and an adjustment also has it work out the
//   raw step and, when the launch change caps it, the launch-change cap.
//   in_ready is high whenever the sequencer is idle, so the next request is
//   taken while the previous result still sits in the output register; if the
//   receiver stalls, the finished result after that waits inside the block.
//   Reset sets target_limit to 100, sample_period to 50, the tick count to 0,
//   the tokens to 1 and empties the output register.
`default_nettype none
module token_rate_utilization_regulator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [trur_pkg::UTIL_W-1:0]   util_sample,
  input  wire logic [trur_pkg::LAUNCH_W-1:0] cur_avg_launches,
  input  wire logic [trur_pkg::LAUNCH_W-1:0] prev_avg_launches,
  input  wire logic                          update_pending,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [trur_pkg::TOKEN_W-1:0]       tokens_per_cycle,
  output logic                               updated,
  input  wire logic                          cfg_wr_en,
  input  wire logic [trur_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [trur_pkg::CFG_W-1:0]    cfg_data
);
  import trur_pkg::*;

  logic [TARGET_W-1:0] target_limit;
  logic [PERIOD_W-1:0] sample_period;
  item_t               req;
  logic                busy;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_limit  <= TARGET_RESET;
      sample_period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET: target_limit  <= cfg_data[TARGET_W-1:0];
        REG_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // request payload
  assign req.util    = util_sample;
  assign req.cur     = cur_avg_launches;
  assign req.prev    = prev_avg_launches;
  assign req.pending = update_pending;
  assign in_ready    = !busy;

  trur_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .start_item (req),
    .target     (target_limit),
    .period     (sample_period),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      tokens_per_cycle <= res.tokens;
      updated          <= res.updated;
    end
  end

endmodule
`default_nettype wire

// File: rtl/trur_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module trur_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [trur_pkg::DIV_DW-1:0]  dividend,
  input  wire logic [trur_pkg::DIV_VW-1:0]  divisor,
  output logic                              done,
  output logic [trur_pkg::DIV_DW-1:0]       quotient,
  output logic [trur_pkg::DIV_VW-1:0]       remainder
);
  import trur_pkg::*;

  logic [DIV_DW-1:0]    quo;
  logic [DIV_VW-1:0]    rem;
  logic [DIV_VW-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_VW:0]      trial;
  logic                 fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[DIV_DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_DW);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend register turns into the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_DW-2:0], fits};
      rem <= fits ? DIV_VW'(trial - {1'b0, dvs}) : trial[DIV_VW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

// File: rtl/trur_core.sv
// sequencer for tick counting, warm-up and the periodic token adjustment
`default_nettype none
module trur_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire trur_pkg::item_t               start_item,
  input  wire logic [trur_pkg::TARGET_W-1:0] target,
  input  wire logic [trur_pkg::PERIOD_W-1:0] period,
  output logic                               busy,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output trur_pkg::res_t                     res
);
  import trur_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DELTA = 4'd4;
  localparam logic [3:0] S_CAP   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_XDIV  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          state;
  logic [TICK_W-1:0]   tick;
  logic [TOKEN_W-1:0]  tokens;
  logic                upd;
  item_t               item;
  logic [PROD_W-1:0]   prod;
  logic [DELTA_W-1:0]  step;
  logic [LHS_W-1:0]    lhs;
  logic [RHS_W-1:0]    rhs;
  logic [NUM_W-1:0]    num;

  logic [PERIOD_W-1:0] period_eff;
  logic                warm;
  logic                up;
  logic [UTIL_W-1:0]   aerr;
  logic [LAUNCH_W-1:0] ad;
  logic                cap;
  logic                div_start;
  logic [DIV_DW-1:0]   div_dividend;
  logic [DIV_VW-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_DW-1:0]   div_quo;
  logic [DIV_VW-1:0]   div_rem;
  logic signed [NEXT_W-1:0] next_s;
  logic [TOKEN_W-1:0]  next_tokens;

  // sample terms
  assign period_eff = (period == '0) ? PERIOD_W'(1) : period;
  assign warm       = tick <= TICK_W'(period_eff);
  assign up         = target > item.util;
  assign aerr       = up ? target - item.util : item.util - target;
  assign ad         = (item.cur > item.prev) ? item.cur - item.prev : item.prev - item.cur;
  assign cap        = (item.cur != item.prev) && (lhs > LHS_W'(rhs));

  // divider requests: tick modulo period, the raw step, the launch cap
  assign div_start = ((state == S_TICK) && !warm) ||
                     ((state == S_PREP) && (aerr != '0) &&
                      (item.util != '0) && (item.cur != '0)) ||
                     ((state == S_CMP) && cap);

  always_comb begin
    unique case (state)
      S_PREP: begin
        div_dividend = DIV_DW'(prod);
        div_divisor  = DIV_VW'({item.util, 2'b00});
      end
      S_CMP: begin
        div_dividend = DIV_DW'(num);
        div_divisor  = DIV_VW'(item.prev) + DIV_VW'(1);
      end
      default: begin
        div_dividend = DIV_DW'(tick);
        div_divisor  = DIV_VW'(period_eff);
      end
    endcase
  end

  trur_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // move the tokens by the step and clamp to the token range
  always_comb begin
    if (up) begin
      next_s = $signed(NEXT_W'(tokens)) + $signed(NEXT_W'(step));
    end else begin
      next_s = $signed(NEXT_W'(tokens)) - $signed(NEXT_W'(step));
    end
    if (next_s < $signed(NEXT_W'(1))) begin
      next_tokens = TOKEN_ONE;
    end else if (next_s > $signed(NEXT_W'(TOKEN_MAX))) begin
      next_tokens = TOKEN_MAX;
    end else begin
      next_tokens = next_s[TOKEN_W-1:0];
    end
  end

  // control state, tick count and tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tick   <= '0;
      tokens <= TOKEN_ONE;
      upd    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (start_item.pending) begin
              upd   <= 1'b0;
              state <= S_DONE;
            end else begin
              tick  <= tick + TICK_W'(1);
              state <= S_TICK;
            end
          end
        end
        S_TICK: begin
          if (warm) begin
            if (tokens <= WARM_MAX) begin
              tokens <= tokens + TOKEN_W'(1);
              upd    <= 1'b1;
            end else begin
              upd <= 1'b0;
            end
            state <= S_DONE;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_done) begin
            if (div_rem != '0) begin
              upd   <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state <= div_start ? S_DELTA : S_CAP;
        end
        S_DELTA: begin
          if (div_done) begin
            state <= S_CAP;
          end
        end
        S_CAP: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= cap ? S_XDIV : S_FIN;
        end
        S_XDIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          tokens <= next_tokens;
          upd    <= 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      item <= start_item;
    end
    if (state == S_MOD) begin
      prod <= PROD_W'(aerr) * PROD_W'(item.cur);
    end
    // zero error gives no step, zero util or launches saturate it
    if (state == S_PREP) begin
      step <= (aerr == '0) ? '0 : DELTA_W'(TOKEN_MAX);
    end
    if ((state == S_DELTA) && div_done) begin
      step <= div_quo[DELTA_W-1:0];
    end
    if (state == S_CAP) begin
      lhs <= LHS_W'(step) * (LHS_W'(item.prev) + LHS_W'(1));
      rhs <= RHS_W'(ad) * RHS_W'(tokens);
      num <= NUM_W'(item.prev) * NUM_W'(ad) + (up ? '0 : NUM_W'(item.prev));
    end
    if ((state == S_XDIV) && div_done) begin
      step <= DELTA_W'(div_quo);
    end
  end

  assign busy       = state != S_IDLE;
  assign res_valid  = state == S_DONE;
  assign res.tokens  = tokens;
  assign res.updated = upd;

endmodule
`default_nettype wire

// File: rtl/trur_checker.sv
// port-level checks of the regulator, bound to the top level
`default_nettype none
module trur_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [trur_pkg::TOKEN_W-1:0] tokens_per_cycle,
  input wire logic                        updated
);
  import trur_pkg::*;

  // reset empties the output and leaves the block ready for a request
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output not empty or block not ready after reset");

  // the token value never drops below one
  a_tokens_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tokens_per_cycle != '0))
    else $error("zero tokens on the result");

  // one request at a time: the block is busy right after taking one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(tokens_per_cycle) && $stable(updated)))
    else $error("stalled result changed");

endmodule

bind token_rate_utilization_regulator trur_checker u_trur_checker (.*);
`default_nettype wire
